FILE: rtl/hctm_pkg.sv
// shared types, constants and saturating adders of the chi-square histogram block
package hctm_pkg;

    localparam int DATA_W      = 32;
    localparam int TAIL_W      = 40;
    localparam int TERM_W      = 41;
    localparam int SUM_W       = 48;
    localparam int CFG_W       = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] MIN_BIN_RESET = CFG_W'(10);

    // one unit of work for the back end
    typedef struct packed {
        logic              do_term;
        logic [TAIL_W-1:0] a;
        logic [TAIL_W-1:0] b;
        logic              last;
        logic              excl;
        logic              clear;
        logic              merged;
        logic              empty;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_ACC,
        S_DIV,
        S_ADD,
        S_FIN
    } t_back_state;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [TAIL_W-1:0] sat_tail(input logic [TAIL_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        logic [TAIL_W:0] s;
        s = {1'b0, a} + {(TAIL_W + 1 - DATA_W)'(0), b};
        return s[TAIL_W] ? {TAIL_W{1'b1}} : s[TAIL_W-1:0];
    endfunction

endpackage

FILE: rtl/histogram_chi_square_tail_merge_top.sv
// top level of the histogram chi-square block with merged low-count tail
// a bin that adds its own term passes the back end through load, prep, the
//   multiply/accumulate steps, the divide steps and the add; a final bin also passes FIN
// throughput: bins enter at one per cycle while the 4-entry request queue has room;
//   tail bins before the last only update the front-end sums; term bins hold the back end
//   until the one-bit-per-cycle restoring divider is done
// reset: synchronous active low, clears sums, tail state, queue and result valid; threshold to 10
module histogram_chi_square_tail_merge_top #(
    parameter int QUEUE_DEPTH = hctm_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [hctm_pkg::DATA_W-1:0]  i_model_count,
    input  logic [hctm_pkg::DATA_W-1:0]  i_data_count,
    input  logic                         i_last_bin,
    input  logic                         i_excluded,
    input  logic                         i_new_scan_point,
    output logic                         empty,
    input  logic                         pop,
    output logic [hctm_pkg::SUM_W-1:0]   o_hist_chi2,
    output logic [hctm_pkg::SUM_W-1:0]   o_total_chi2,
    output logic [hctm_pkg::SUM_W-1:0]   o_selected_chi2,
    output logic                         o_tail_merged,
    output logic                         o_empty_tail,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hctm_pkg::CFG_W-1:0]   i_cfg_data
);
    import hctm_pkg::*;

    logic accept;
    logic q_push;
    logic q_rd;
    logic q_empty;
    t_cmd q_wr_data;
    t_cmd q_rd_data;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    hctm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_model_count    (i_model_count),
        .i_data_count     (i_data_count),
        .i_last_bin       (i_last_bin),
        .i_excluded       (i_excluded),
        .i_new_scan_point (i_new_scan_point),
        .o_push           (q_push),
        .o_cmd            (q_wr_data)
    );

    hctm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_push),
        .i_wr_data (q_wr_data),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    hctm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_data        (q_rd_data),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_hist_chi2     (o_hist_chi2),
        .o_total_chi2    (o_total_chi2),
        .o_selected_chi2 (o_selected_chi2),
        .o_tail_merged   (o_tail_merged),
        .o_empty_tail    (o_empty_tail)
    );

endmodule

FILE: rtl/hctm_front.sv
// front end: threshold register, bin classification and tail accumulation
module hctm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr,
    input  logic [hctm_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  logic [hctm_pkg::DATA_W-1:0]   i_model_count,
    input  logic [hctm_pkg::DATA_W-1:0]   i_data_count,
    input  logic                          i_last_bin,
    input  logic                          i_excluded,
    input  logic                          i_new_scan_point,
    output logic                          o_push,
    output hctm_pkg::t_cmd                o_cmd
);
    import hctm_pkg::*;

    logic [CFG_W-1:0]  r_min_bin_count;
    logic              r_in_tail;
    logic [TAIL_W-1:0] r_tail_m;
    logic [TAIL_W-1:0] r_tail_d;
    logic              r_clr_pend;

    logic [DATA_W-1:0] thr;
    logic              direct;
    logic [TAIL_W-1:0] n_tail_m;
    logic [TAIL_W-1:0] n_tail_d;
    logic              tail_zero;

    assign thr       = {(DATA_W - CFG_W - 8)'(0), r_min_bin_count, 8'h00};
    assign direct    = !r_in_tail && (i_data_count >= thr);
    assign n_tail_m  = sat_tail(r_tail_m, i_model_count);
    assign n_tail_d  = sat_tail(r_tail_d, i_data_count);
    assign tail_zero = (n_tail_m == '0) && (n_tail_d == '0);

    always_comb begin
        o_cmd.last   = i_last_bin;
        o_cmd.excl   = i_excluded;
        o_cmd.clear  = r_clr_pend | i_new_scan_point;
        if (direct) begin
            o_cmd.do_term = 1'b1;
            o_cmd.a       = {(TAIL_W - DATA_W)'(0), i_model_count};
            o_cmd.b       = {(TAIL_W - DATA_W)'(0), i_data_count};
            o_cmd.merged  = 1'b0;
            o_cmd.empty   = 1'b0;
        end else begin
            o_cmd.do_term = !tail_zero;
            o_cmd.a       = n_tail_m;
            o_cmd.b       = n_tail_d;
            o_cmd.merged  = 1'b1;
            o_cmd.empty   = tail_zero;
        end
    end

    // tail bins other than the last one only update local sums
    assign o_push = i_accept && (direct || i_last_bin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bin_count <= MIN_BIN_RESET;
            r_in_tail       <= 1'b0;
            r_tail_m        <= '0;
            r_tail_d        <= '0;
            r_clr_pend      <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_min_bin_count <= i_cfg_data;
            end
            if (i_accept) begin
                if (i_last_bin) begin
                    r_in_tail  <= 1'b0;
                    r_tail_m   <= '0;
                    r_tail_d   <= '0;
                    r_clr_pend <= 1'b0;
                end else begin
                    r_clr_pend <= r_clr_pend | i_new_scan_point;
                    if (!direct) begin
                        r_in_tail <= 1'b1;
                        r_tail_m  <= n_tail_m;
                        r_tail_d  <= n_tail_d;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/hctm_queue.sv
// short request queue between front and back end
module hctm_queue #(
    parameter int DEPTH = hctm_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  hctm_pkg::t_cmd i_wr_data,
    input  logic           i_rd,
    output hctm_pkg::t_cmd o_rd_data,
    output logic           o_full,
    output logic           o_empty
);
    import hctm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/hctm_back.sv
// back end: square over sum with a shared multiplier and serial divider, sums, result register
module hctm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  hctm_pkg::t_cmd               i_q_data,
    output logic                         o_q_rd,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [hctm_pkg::SUM_W-1:0]   o_hist_chi2,
    output logic [hctm_pkg::SUM_W-1:0]   o_total_chi2,
    output logic [hctm_pkg::SUM_W-1:0]   o_selected_chi2,
    output logic                         o_tail_merged,
    output logic                         o_empty_tail
);
    import hctm_pkg::*;

    localparam int HALF_W = (TERM_W + 1) / 2;
    localparam int PROD_W = 2 * HALF_W;
    localparam int SQ_W   = 2 * TERM_W;
    localparam int CNT_W  = $clog2(TERM_W + 1);
    localparam logic [1:0]       K_LO_LO = 2'd0;
    localparam logic [1:0]       K_HI_LO = 2'd1;
    localparam logic [1:0]       K_HI_HI = 2'd2;
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(TERM_W);

    t_back_state       r_state;
    t_back_state       n_state;
    t_cmd              r_cmd;
    logic [TERM_W-1:0] r_diff;
    logic [TERM_W-1:0] r_den;
    logic [1:0]        r_k;
    logic [PROD_W-1:0] r_prod;
    logic [SQ_W-1:0]   r_sq;
    logic [TERM_W-1:0] r_rem;
    logic [TERM_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_hist;
    logic [SUM_W-1:0]  r_all;
    logic [SUM_W-1:0]  r_chosen;
    logic              r_out_valid;
    logic [SUM_W-1:0]  r_out_hist;
    logic [SUM_W-1:0]  r_out_all;
    logic [SUM_W-1:0]  r_out_chosen;
    logic              r_out_merged;
    logic              r_out_empty;

    logic [TERM_W-1:0] diff;
    logic [TERM_W-1:0] den;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [SQ_W-1:0]   prod_shifted;
    logic [SQ_W-1:0]   n_sq;
    logic [TERM_W:0]   div_trial;
    logic [TERM_W:0]   div_sub;
    logic              div_ge;
    logic              out_wr;
    logic [SUM_W-1:0]  all_base;
    logic [SUM_W-1:0]  chosen_base;

    assign diff = (r_cmd.a >= r_cmd.b) ? {1'b0, r_cmd.a - r_cmd.b} : {1'b0, r_cmd.b - r_cmd.a};
    assign den  = {1'b0, r_cmd.a} + {1'b0, r_cmd.b};

    // diff = hi * 2^HALF_W + lo, square built from three partial products
    always_comb begin
        unique case (r_k)
            K_LO_LO: begin
                mul_a = r_diff[HALF_W-1:0];
                mul_b = r_diff[HALF_W-1:0];
            end
            K_HI_LO: begin
                mul_a = HALF_W'(r_diff[TERM_W-1:HALF_W]);
                mul_b = r_diff[HALF_W-1:0];
            end
            default: begin
                mul_a = HALF_W'(r_diff[TERM_W-1:HALF_W]);
                mul_b = HALF_W'(r_diff[TERM_W-1:HALF_W]);
            end
        endcase
    end

    always_comb begin
        unique case (r_k)
            K_LO_LO: prod_shifted = SQ_W'(r_prod);
            K_HI_LO: prod_shifted = SQ_W'(r_prod) << (HALF_W + 1);
            default: prod_shifted = SQ_W'(r_prod) << (2 * HALF_W);
        endcase
    end

    assign n_sq      = r_sq + prod_shifted;
    assign div_trial = {r_rem, r_sq[TERM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_den});
    assign div_sub   = div_trial - {1'b0, r_den};

    assign all_base    = r_cmd.clear ? '0 : r_all;
    assign chosen_base = r_cmd.clear ? '0 : r_chosen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_rd  = 1'b0;
        out_wr  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd = 1'b1;
                    if (i_q_data.do_term) begin
                        n_state = S_PREP;
                    end else if (i_q_data.last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_PREP: n_state = (den == '0) ? S_ADD : S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = (r_k == K_HI_HI) ? S_DIV : S_MUL;
            S_DIV:  n_state = (r_cnt == CNT_W'(1)) ? S_ADD : S_DIV;
            S_ADD:  n_state = r_cmd.last ? S_FIN : S_IDLE;
            S_FIN: begin
                if (!r_out_valid || i_pop) begin
                    out_wr  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd <= i_q_data;
            end
            S_PREP: begin
                r_diff <= diff;
                r_den  <= den;
                r_sq   <= '0;
                r_k    <= K_LO_LO;
                r_quo  <= '0;
            end
            S_MUL: begin
                r_prod <= mul_a * mul_b;
            end
            S_ACC: begin
                if (r_k == K_HI_HI) begin
                    r_sq  <= n_sq;
                    r_rem <= n_sq[SQ_W-1:TERM_W];
                    r_cnt <= DIV_STEPS;
                end else begin
                    r_sq <= n_sq;
                    r_k  <= r_k + 1'b1;
                end
            end
            S_DIV: begin
                r_rem <= div_ge ? div_sub[TERM_W-1:0] : div_trial[TERM_W-1:0];
                r_sq  <= r_sq << 1;
                r_quo <= {r_quo[TERM_W-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_all       <= '0;
            r_chosen    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_ADD) begin
                r_hist <= sat_sum(r_hist, SUM_W'(r_quo));
            end
            if (out_wr) begin
                r_hist      <= '0;
                r_all       <= sat_sum(all_base, r_hist);
                r_chosen    <= r_cmd.excl ? chosen_base : sat_sum(chosen_base, r_hist);
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out_hist   <= r_hist;
            r_out_all    <= sat_sum(all_base, r_hist);
            r_out_chosen <= r_cmd.excl ? chosen_base : sat_sum(chosen_base, r_hist);
            r_out_merged <= r_cmd.merged;
            r_out_empty  <= r_cmd.empty;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_hist_chi2     = r_out_hist;
    assign o_total_chi2    = r_out_all;
    assign o_selected_chi2 = r_out_chosen;
    assign o_tail_merged   = r_out_merged;
    assign o_empty_tail    = r_out_empty;

    a_div_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("divider running with zero divisor");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_quo <= r_diff))
        else $error("term exceeds difference");

    a_fin_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> r_cmd.last)
        else $error("result formed on a non-final bin");

endmodule

FILE: tb/sv/histogram_chi_square_tail_merge_top_tb.sv
// self-checking testbench for the histogram chi-square block with merged low-count tail
`timescale 1ns / 100ps

module histogram_chi_square_tail_merge_top_tb;

    import hctm_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = (QUEUE_DEPTH + 1) * 60;
    localparam int          MAX_BINS     = 64;
    localparam logic [63:0] TAIL_CAP     = (64'd1 << TAIL_W) - 64'd1;
    localparam logic [63:0] SUM_CAP      = (64'd1 << SUM_W) - 64'd1;

    typedef struct packed {
        logic [SUM_W-1:0] hist_chi2;
        logic [SUM_W-1:0] total_chi2;
        logic [SUM_W-1:0] selected_chi2;
        logic             tail_merged;
        logic             empty_tail;
    } t_hist_result;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               push             = 1'b0;
    logic               full;
    logic [DATA_W-1:0]  i_model_count    = '0;
    logic [DATA_W-1:0]  i_data_count     = '0;
    logic               i_last_bin       = 1'b0;
    logic               i_excluded       = 1'b0;
    logic               i_new_scan_point = 1'b0;
    logic               empty;
    logic               pop              = 1'b0;
    logic [SUM_W-1:0]   o_hist_chi2;
    logic [SUM_W-1:0]   o_total_chi2;
    logic [SUM_W-1:0]   o_selected_chi2;
    logic               o_tail_merged;
    logic               o_empty_tail;
    logic               i_cfg_valid      = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data       = '0;

    // chi-square predictor state
    logic [CFG_W-1:0]   min_bin_thr = MIN_BIN_RESET;
    logic               pred_in_tail = 1'b0;
    logic [TAIL_W-1:0]  pred_tail_model = '0;
    logic [TAIL_W-1:0]  pred_tail_data = '0;
    logic [SUM_W-1:0]   pred_hist_sum = '0;
    logic [SUM_W-1:0]   pred_all_sum = '0;
    logic [SUM_W-1:0]   pred_chosen_sum = '0;

    t_hist_result       chi2_expected[$];

    int send_idle_pct    = 0;
    int pop_stall_pct    = 0;
    int cycle_count      = 0;
    int fail_count       = 0;
    int bins_sent        = 0;
    int results_checked  = 0;
    int merged_seen      = 0;
    int empty_tails_seen = 0;

    histogram_chi_square_tail_merge_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_model_count    (i_model_count),
        .i_data_count     (i_data_count),
        .i_last_bin       (i_last_bin),
        .i_excluded       (i_excluded),
        .i_new_scan_point (i_new_scan_point),
        .empty            (empty),
        .pop              (pop),
        .o_hist_chi2      (o_hist_chi2),
        .o_total_chi2     (o_total_chi2),
        .o_selected_chi2  (o_selected_chi2),
        .o_tail_merged    (o_tail_merged),
        .o_empty_tail     (o_empty_tail),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] cap);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, cap}) ? cap : s[63:0];
    endfunction

    // floor((a-b)^2 / (a+b)), zero when both are zero
    function automatic logic [SUM_W-1:0] np_term(input logic [TAIL_W-1:0] a,
                                                 input logic [TAIL_W-1:0] b);
        logic [TAIL_W-1:0]   diff;
        logic [TAIL_W:0]     den;
        logic [2*TAIL_W+1:0] sq;
        logic [2*TAIL_W+1:0] q;
        diff = (a >= b) ? a - b : b - a;
        den  = {1'b0, a} + {1'b0, b};
        if (den == '0)
            return '0;
        sq = (2*TAIL_W+2)'(diff) * (2*TAIL_W+2)'(diff);
        q  = sq / (2*TAIL_W+2)'(den);
        return q[SUM_W-1:0];
    endfunction

    task automatic predict_bin(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] d,
                               input logic last, input logic excl, input logic clr);
        t_hist_result r;
        if (clr) begin
            pred_all_sum    = '0;
            pred_chosen_sum = '0;
        end
        if (!pred_in_tail && d >= {8'd0, min_bin_thr, 8'd0}) begin
            pred_hist_sum = SUM_W'(clamp_add(64'(pred_hist_sum),
                                             64'(np_term(TAIL_W'(m), TAIL_W'(d))), SUM_CAP));
        end else begin
            pred_in_tail    = 1'b1;
            pred_tail_model = TAIL_W'(clamp_add(64'(pred_tail_model), 64'(m), TAIL_CAP));
            pred_tail_data  = TAIL_W'(clamp_add(64'(pred_tail_data), 64'(d), TAIL_CAP));
        end
        if (last) begin
            r.tail_merged = pred_in_tail;
            r.empty_tail  = 1'b0;
            if (pred_in_tail) begin
                if (pred_tail_model == '0 && pred_tail_data == '0)
                    r.empty_tail = 1'b1;
                else
                    pred_hist_sum = SUM_W'(clamp_add(64'(pred_hist_sum),
                        64'(np_term(pred_tail_model, pred_tail_data)), SUM_CAP));
            end
            pred_all_sum = SUM_W'(clamp_add(64'(pred_all_sum), 64'(pred_hist_sum), SUM_CAP));
            if (!excl)
                pred_chosen_sum = SUM_W'(clamp_add(64'(pred_chosen_sum), 64'(pred_hist_sum),
                                                   SUM_CAP));
            r.hist_chi2     = pred_hist_sum;
            r.total_chi2    = pred_all_sum;
            r.selected_chi2 = pred_chosen_sum;
            chi2_expected.insert(chi2_expected.size(), r);
            pred_in_tail    = 1'b0;
            pred_tail_model = '0;
            pred_tail_data  = '0;
            pred_hist_sum   = '0;
        end
    endtask

    // one bin request; push stays high between back-to-back bins
    task automatic send_bin(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] d,
                            input logic last, input logic excl, input logic clr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_model_count    <= m;
        i_data_count     <= d;
        i_last_bin       <= last;
        i_excluded       <= excl;
        i_new_scan_point <= clr;
        do
            @(posedge i_clk);
        while (full !== 1'b0);
        predict_bin(m, d, last, excl, clr);
        bins_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (chi2_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_bin_count(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        min_bin_thr = value;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_hist_result want;
        if (chi2_expected.size() == 0) begin
            $error("result popped with no histogram pending: hist_chi2 0x%0h", o_hist_chi2);
            fail_count++;
        end else begin
            want = chi2_expected.pop_front();
            check_field("hist_chi2", 64'(want.hist_chi2), 64'(o_hist_chi2));
            check_field("total_chi2", 64'(want.total_chi2), 64'(o_total_chi2));
            check_field("selected_chi2", 64'(want.selected_chi2), 64'(o_selected_chi2));
            check_field("tail_merged", 64'(want.tail_merged), 64'(o_tail_merged));
            check_field("empty_tail", 64'(want.empty_tail), 64'(o_empty_tail));
            results_checked++;
            if (want.tail_merged)
                merged_seen++;
            if (want.empty_tail)
                empty_tails_seen++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0)
            check_result();
        pop <= i_rst_n && ($urandom_range(0, 99) >= pop_stall_pct);
    end

    function automatic logic [DATA_W-1:0] count_above();
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] r;
        base = {8'd0, min_bin_thr, 8'd0};
        case ($urandom_range(0, 3))
            0: return base + DATA_W'($urandom_range(0, 255));
            1: return base + DATA_W'($urandom_range(0, 1 << 20));
            2: begin
                r = $urandom;
                return (r < base) ? base : r;
            end
            default: return '1;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] count_below();
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] r;
        base = {8'd0, min_bin_thr, 8'd0};
        // with a zero threshold nothing is below, the bin just stays a term bin
        if (base == '0)
            return '0;
        case ($urandom_range(0, 3))
            0: return DATA_W'($urandom_range(0, base - 1));
            1: return base - 1;
            2: return '0;
            default: begin
                r = DATA_W'($urandom_range(0, 255));
                return (r < base) ? r : base - 1;
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] model_for(input logic [DATA_W-1:0] d);
        case ($urandom_range(0, 5))
            0: return d;
            1: return d + DATA_W'($urandom_range(0, 255));
            2: return d ^ DATA_W'($urandom_range(0, 16'hFFFF));
            3: return $urandom;
            4: return '0;
            default: return '1;
        endcase
    endfunction

    // mostly term bins falling into a tail, some fully random histograms
    task automatic random_histograms(input int n_bins);
        int                sent_here;
        int                nbins;
        int                brk;
        int                b;
        logic              noisy;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] d;
        logic              clr;
        sent_here = 0;
        while (sent_here < n_bins) begin
            nbins = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 10)
                                                : $urandom_range(11, MAX_BINS);
            if (nbins > n_bins - sent_here)
                nbins = n_bins - sent_here;
            noisy = ($urandom_range(0, 4) == 0);
            brk   = $urandom_range(0, nbins);
            for (b = 0; b < nbins; b++) begin
                if (noisy)
                    d = $urandom_range(0, 1) ? DATA_W'($urandom)
                                             : DATA_W'($urandom_range(0, 4095));
                else if (b < brk)
                    d = count_above();
                else if (b == brk)
                    d = count_below();
                else
                    d = $urandom_range(0, 1) ? count_above() : count_below();
                m   = model_for(d);
                clr = (b == 0) ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 29) == 0);
                send_bin(m, d, b == nbins - 1, $urandom_range(0, 2) == 0, clr);
                sent_here++;
            end
        end
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] thr, input int send_pct,
                                    input int stall_pct, input int n_bins);
        write_min_bin_count(thr);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
        random_histograms(n_bins);
    endtask

    // threshold at its reset value of 10 whole counts
    task automatic test_directed();
        send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
        // a term bin at the exact threshold and one above it, then a tail that keeps high-count bins
        send_bin(32'hFFFF_FFFF, 32'h0000_0A00, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_1234, 32'h0000_09FF, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0005, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        // tail with both sums zero is skipped
        send_bin(32'h0000_0A00, 32'h0000_0A00, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        // clear on a middle bin
        send_bin(32'h0000_0064, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0007, 32'h0000_5000, 1'b0, 1'b0, 1'b1);
        send_bin(32'hFFFF_FFFF, 32'h0000_0010, 1'b1, 1'b0, 1'b0);
        send_bin(32'h0000_0800, 32'h0000_2000, 1'b1, 1'b1, 1'b0);
    endtask

    // zero threshold lets an all-zero bin through as a term of zero
    task automatic test_zero_threshold();
        write_min_bin_count(16'd0);
        send_bin(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        send_bin(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        send_bin(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_max_threshold();
        write_min_bin_count(16'hFFFF);
        send_bin(32'h1234_5678, 32'h00FF_FF00, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_bin(32'hFFFF_FFFF, 32'h00FF_FEFF, 1'b0, 1'b0, 1'b0);
        send_bin(32'h0000_0100, 32'h0000_0200, 1'b1, 1'b0, 1'b0);
        send_bin(32'hFFFF_FFFF, 32'h00FF_FF00, 1'b1, 1'b1, 1'b0);
    endtask

    // a long tail saturates the data sum while the model sum stays below its cap
    task automatic test_sum_saturation();
        int b;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_bin(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
        for (b = 1; b <= 257; b++)
            send_bin(32'h8000_0000, 32'hFFFF_FFFF, b == 257, 1'b0, 1'b0);
    endtask

    task automatic test_random_mix();
        run_random_phase(16'($urandom_range(1, 40)), 0, 0, 30);
        run_random_phase(16'd0, 50, 0, 30);
        run_random_phase(16'hFFFF, 0, 50, 30);
        run_random_phase(16'($urandom_range(0, 16'hFFFF)), 38, 38, 30);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_zero_threshold();
        test_max_threshold();
        test_sum_saturation();
        test_random_mix();
        wait_idle();
        $display("chi-square histogram run: %0d bins, %0d results, %0d merged tails, %0d empty",
                 bins_sent, results_checked, merged_seen, empty_tails_seen);
        $display("thresholds 0/10/65535/random, a saturated tail sum, four push/pop pacing mixes");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
